>>> sv/tick_driven_calendar_clock_defines.svh
// Assertion macros used by the top-level RTL file of the calendar clock.
// In synthesis builds they expand to nothing.
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_DEFINES_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define TDCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("calendar clock check failed");

// Checks that a condition at one edge is followed by another at the next edge.
`define TDCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar clock sequence check failed");

`else

`define TDCC_ASSERT(lbl, clk, rst_n, prop)
`define TDCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/tdcc_pkg.sv
package tdcc_pkg;

    // Transaction kinds on the input channel.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // Configuration register map.
    localparam int unsigned APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_TICKS_PER_SECOND = 2'd0;
    localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
    localparam logic [3:0] MONTHS_PER_YEAR    = 4'd12;

    localparam logic [15:0] YEAR_RESET  = 16'd2000;
    localparam logic [3:0]  MONTH_RESET = 4'd1;
    localparam logic [4:0]  DAY_RESET   = 5'd1;

    // Multiplicative inverse of 25 modulo 2^16. A 16-bit year is a multiple
    // of 25 exactly when year * YEAR_INV25 (mod 2^16) is at most 65535 / 25.
    localparam logic [15:0] YEAR_INV25   = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT  = 16'(65535 / 25);

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    // Month lengths; months with no meaning count as 31 days.
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

>>> sv/tick_driven_calendar_clock.sv
// Tick-driven calendar clock. Every input transaction is either one timer
// tick or a command that loads the date and time; every input transaction
// produces exactly one result transaction carrying the date, the time, the
// second pulse and the running tick count as they stand after that input.
// The block takes one input transaction per clock cycle while results are
// taken, and the result is registered and presented in the cycle after
// acceptance; the rate is set by the single result stage, which is refilled
// in the same cycle that its contents are taken. The longest path runs from
// the calendar registers through the leap-year test (one 16 by 16 multiply by
// a constant and a compare) and the second-to-year carry chain back into
// those registers. The prescaler length is held in the ticks_per_second
// register at byte address 0 of the configuration port and resets to 1000; it
// should only be written while no transaction is in flight. After reset the
// clock reads midnight on the first of January 2000 with a tick count of zero.
`include "tick_driven_calendar_clock_defines.svh"

module tick_driven_calendar_clock (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,

    // Input channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [15:0]                         s_set_year,
    input  logic [3:0]                          s_set_month,
    input  logic [4:0]                          s_set_day,
    input  logic [4:0]                          s_set_hour,
    input  logic [5:0]                          s_set_minute,
    input  logic [5:0]                          s_set_second,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_year_now,
    output logic [3:0]                          m_month_now,
    output logic [4:0]                          m_day_now,
    output logic [4:0]                          m_hour_now,
    output logic [5:0]                          m_minute_now,
    output logic [5:0]                          m_second_now,
    output logic                                m_second_pulse,
    output logic [31:0]                         m_tick_total
);

    // Configuration register.
    logic [15:0]    tps_reg;
    logic           cfg_write;

    // Clock state. The calendar and tick count registers double as the
    // result stage: they always hold the state after the most recently
    // accepted transaction, which is exactly what the pending result shows.
    tdcc_pkg::cal_t cal_reg;
    tdcc_pkg::cal_t cal_next;
    tdcc_pkg::cal_t cal_adv;
    tdcc_pkg::cal_t cal_load;
    logic [31:0]    tick_reg;
    logic [31:0]    tick_next;
    logic [15:0]    sub_reg;
    logic [15:0]    sub_next;
    logic [16:0]    sub_inc;
    logic           pulse_reg;
    logic           pulse_next;
    logic           tick_pulse;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic           s_fire;

    // ------------------------------------------------------------------
    // Configuration port: zero wait states, one register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == tdcc_pkg::ADDR_TICKS_PER_SECOND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= tdcc_pkg::TICKS_PER_SECOND_RESET;
        end else if (cfg_write) begin
            tps_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr == tdcc_pkg::ADDR_TICKS_PER_SECOND) begin
            prdata = 32'(tps_reg);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A new transaction is taken whenever the result stage is
    // empty or is being emptied in the same cycle, so ticks may arrive
    // back to back at full clock rate.
    // ------------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Prescaler. The increment is taken one bit wider so that a count of
    // 65535 still compares correctly; a ticks_per_second of zero, or one
    // lowered below the current count, completes a second on the next tick.
    // ------------------------------------------------------------------
    assign sub_inc    = {1'b0, sub_reg} + 17'd1;
    assign tick_pulse = (sub_inc >= {1'b0, tps_reg});

    tdcc_advance u_advance (
        .cur (cal_reg),
        .nxt (cal_adv)
    );

    // A load command stores the fields exactly as given, with no range check.
    always_comb begin
        cal_load.year   = s_set_year;
        cal_load.month  = s_set_month;
        cal_load.day    = s_set_day;
        cal_load.hour   = s_set_hour;
        cal_load.minute = s_set_minute;
        cal_load.second = s_set_second;
    end

    always_comb begin
        cal_next     = cal_reg;
        tick_next    = tick_reg;
        sub_next     = sub_reg;
        pulse_next   = pulse_reg;
        m_valid_next = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            m_valid_next = 1'b1;
            if (s_kind == tdcc_pkg::KIND_SET) begin
                cal_next   = cal_load;
                tick_next  = '0;
                sub_next   = '0;
                pulse_next = 1'b0;
            end else begin
                tick_next  = tick_reg + 32'd1;
                pulse_next = tick_pulse;
                if (tick_pulse) begin
                    sub_next = '0;
                    cal_next = cal_adv;
                end else begin
                    sub_next = sub_inc[15:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.year   <= tdcc_pkg::YEAR_RESET;
            cal_reg.month  <= tdcc_pkg::MONTH_RESET;
            cal_reg.day    <= tdcc_pkg::DAY_RESET;
            cal_reg.hour   <= '0;
            cal_reg.minute <= '0;
            cal_reg.second <= '0;
            tick_reg       <= '0;
            sub_reg        <= '0;
            pulse_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cal_reg     <= cal_next;
            tick_reg    <= tick_next;
            sub_reg     <= sub_next;
            pulse_reg   <= pulse_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result channel.
    // ------------------------------------------------------------------
    assign m_valid        = m_valid_reg;
    assign m_year_now     = cal_reg.year;
    assign m_month_now    = cal_reg.month;
    assign m_day_now      = cal_reg.day;
    assign m_hour_now     = cal_reg.hour;
    assign m_minute_now   = cal_reg.minute;
    assign m_second_now   = cal_reg.second;
    assign m_second_pulse = pulse_reg;
    assign m_tick_total   = tick_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A load command clears the tick count and never reports a second.
    `TDCC_ASSERT_NEXT(a_load_clears, aclk, aresetn,
        s_fire && (s_kind == tdcc_pkg::KIND_SET),
        m_valid && (m_tick_total == 32'd0) && !m_second_pulse)

    // A tick advances the tick count by exactly one.
    `TDCC_ASSERT_NEXT(a_tick_counts, aclk, aresetn,
        s_fire && (s_kind == tdcc_pkg::KIND_TICK),
        m_tick_total == ($past(tick_reg) + 32'd1))

    // The seconds field only moves on a tick that completes a second.
    `TDCC_ASSERT_NEXT(a_second_only_on_pulse, aclk, aresetn,
        s_fire && (s_kind == tdcc_pkg::KIND_TICK),
        m_second_pulse || (m_second_now == $past(cal_reg.second)))

    // While a pulsed result is on show, the prescaler has restarted.
    `TDCC_ASSERT(a_pulse_restarts_prescaler, aclk, aresetn,
        !(m_valid && m_second_pulse) || (sub_reg == 16'd0))

endmodule

>>> sv/tdcc_advance.sv
module tdcc_advance (
    input  tdcc_pkg::cal_t cur,
    output tdcc_pkg::cal_t nxt
);

    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;
    logic [4:0]  day_inc;
    logic [3:0]  month_inc;
    logic [15:0] year_scaled;
    logic        div25;
    logic        leap;
    logic [4:0]  month_len;

    // Gregorian rule: divisible by 4, and not by 100 unless also by 400.
    // With the year a multiple of 4, that is: not a multiple of 25, or a
    // multiple of 16.
    assign year_scaled = cur.year * tdcc_pkg::YEAR_INV25;
    assign div25       = (year_scaled <= tdcc_pkg::DIV25_LIMIT);
    assign leap        = (cur.year[1:0] == 2'b00) && (!div25 || (cur.year[3:0] == 4'b0000));
    assign month_len   = tdcc_pkg::days_in_month(cur.month, leap);

    assign sec_inc   = cur.second + 6'd1;
    assign min_inc   = cur.minute + 6'd1;
    assign hour_inc  = cur.hour + 5'd1;
    assign day_inc   = cur.day + 5'd1;
    assign month_inc = cur.month + 4'd1;

    // Each field wraps inside its own width first. Second, minute and hour carry
    // at or above their limit; day and month carry above it or on wrapping to zero.
    always_comb begin
        nxt = cur;
        if (sec_inc < tdcc_pkg::SECONDS_PER_MINUTE) begin
            nxt.second = sec_inc;
        end else begin
            nxt.second = '0;
            if (min_inc < tdcc_pkg::MINUTES_PER_HOUR) begin
                nxt.minute = min_inc;
            end else begin
                nxt.minute = '0;
                if (hour_inc < tdcc_pkg::HOURS_PER_DAY) begin
                    nxt.hour = hour_inc;
                end else begin
                    nxt.hour = '0;
                    if ((day_inc != 5'd0) && (day_inc <= month_len)) begin
                        nxt.day = day_inc;
                    end else begin
                        nxt.day = tdcc_pkg::DAY_RESET;
                        if ((month_inc != 4'd0) && (month_inc <= tdcc_pkg::MONTHS_PER_YEAR)) begin
                            nxt.month = month_inc;
                        end else begin
                            nxt.month = tdcc_pkg::MONTH_RESET;
                            nxt.year  = cur.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is bounded by a cycle limit. It is several times the slowest
    // correct run: every transaction meets the longest sender gap and the
    // longest receiver stall, and the long receiver hold-off comes on top.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 160;
    localparam int TAIL_CYCLES  = 4;

    // One input transaction: a tick, or a load with the date and time to store.
    typedef struct packed {
        logic           kind;
        tdcc_pkg::cal_t when;
    } command_t;

    // One result transaction as the block should present it.
    typedef struct packed {
        tdcc_pkg::cal_t now;
        logic           pulse;
        logic [31:0]    ticks;
    } reading_t;

    // The class keeps its own copy of the clock state and the prescaler
    // length. Each accepted input transaction advances that copy and queues
    // the reading that the block must report for it. Each result transaction
    // is checked against the oldest queued reading.
    class calendar_tracker;
        logic [15:0]    ticks_per_second;
        logic [31:0]    tick_count;
        logic [16:0]    prescale;
        tdcc_pkg::cal_t now;
        reading_t       expected_readings[$];
        int             errors;

        function new();
            ticks_per_second = tdcc_pkg::TICKS_PER_SECOND_RESET;
            tick_count       = 32'd0;
            prescale         = 17'd0;
            now.year         = 16'd2000;
            now.month        = 4'd1;
            now.day          = 5'd1;
            now.hour         = 5'd0;
            now.minute       = 6'd0;
            now.second       = 6'd0;
            errors           = 0;
        endfunction

        // Gregorian month length. Months with no meaning count as 31 days.
        function logic [4:0] month_length(logic [3:0] month, logic [15:0] year);
            logic       leap;
            logic [4:0] days;
            leap = (year % 16'd4 == 16'd0) &&
                   ((year % 16'd100 != 16'd0) || (year % 16'd400 == 16'd0));
            case (month)
                4'd2:                    days = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
                default:                 days = 5'd31;
            endcase
            return days;
        endfunction

        // Carry chain from the second up to the year. Every field wraps at
        // its own width before it is compared with its limit.
        function void advance_second();
            now.second = now.second + 6'd1;
            if (now.second < 6'd60)
                return;
            now.second = 6'd0;
            now.minute = now.minute + 6'd1;
            if (now.minute < 6'd60)
                return;
            now.minute = 6'd0;
            now.hour = now.hour + 5'd1;
            if (now.hour < 5'd24)
                return;
            now.hour = 5'd0;
            now.day = now.day + 5'd1;
            if (now.day != 5'd0 && now.day <= month_length(now.month, now.year))
                return;
            now.day = 5'd1;
            now.month = now.month + 4'd1;
            if (now.month != 4'd0 && now.month <= 4'd12)
                return;
            now.month = 4'd1;
            now.year = now.year + 16'd1;
        endfunction

        function void accept_command(command_t c);
            reading_t r;
            r.pulse = 1'b0;
            if (c.kind == tdcc_pkg::KIND_SET) begin
                now        = c.when;
                tick_count = 32'd0;
                prescale   = 17'd0;
            end else begin
                tick_count = tick_count + 32'd1;
                prescale   = prescale + 17'd1;
                if (prescale >= {1'b0, ticks_per_second}) begin
                    prescale = 17'd0;
                    r.pulse  = 1'b1;
                    advance_second();
                end
                prescale = {1'b0, prescale[15:0]};
            end
            r.now   = now;
            r.ticks = tick_count;
            expected_readings.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void compare_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0) begin
                $error("result transaction with no reading expected");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            check_field("year_now", 32'(want.now.year), 32'(got.now.year));
            check_field("month_now", 32'(want.now.month), 32'(got.now.month));
            check_field("day_now", 32'(want.now.day), 32'(got.now.day));
            check_field("hour_now", 32'(want.now.hour), 32'(got.now.hour));
            check_field("minute_now", 32'(want.now.minute), 32'(got.now.minute));
            check_field("second_now", 32'(want.now.second), 32'(got.now.second));
            check_field("second_pulse", 32'(want.pulse), 32'(got.pulse));
            check_field("tick_total", want.ticks, got.ticks);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tdcc_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [15:0] s_set_year;
    logic [3:0]  s_set_month;
    logic [4:0]  s_set_day;
    logic [4:0]  s_set_hour;
    logic [5:0]  s_set_minute;
    logic [5:0]  s_set_second;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_year_now;
    logic [3:0]  m_month_now;
    logic [4:0]  m_day_now;
    logic [4:0]  m_hour_now;
    logic [5:0]  m_minute_now;
    logic [5:0]  m_second_now;
    logic        m_second_pulse;
    logic [31:0] m_tick_total;

    calendar_tracker clock_model = new();

    // Raised by the sender to make the receiver hold off for a long stretch.
    logic hold_request = 1'b0;
    int   send_calm    = 0;
    int   cycle_count  = 0;

    tick_driven_calendar_clock dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_set_year     (s_set_year),
        .s_set_month    (s_set_month),
        .s_set_day      (s_set_day),
        .s_set_hour     (s_set_hour),
        .s_set_minute   (s_set_minute),
        .s_set_second   (s_set_second),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year_now     (m_year_now),
        .m_month_now    (m_month_now),
        .m_day_now      (m_day_now),
        .m_hour_now     (m_hour_now),
        .m_minute_now   (m_minute_now),
        .m_second_now   (m_second_now),
        .m_second_pulse (m_second_pulse),
        .m_tick_total   (m_tick_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Idle lengths for both sides. Most gaps are short and a few are long;
    // now and then a calm stretch with no gaps at all follows.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random field contents, each bit free. Used for noisy loads and as the
    // ignored payload of ticks.
    function automatic command_t random_command(logic kind);
        command_t c;
        c.kind        = kind;
        c.when.year   = 16'($urandom());
        c.when.month  = 4'($urandom());
        c.when.day    = 5'($urandom());
        c.when.hour   = 5'($urandom());
        c.when.minute = 6'($urandom());
        c.when.second = 6'($urandom());
        return c;
    endfunction

    // A load that sits just before a rollover, so that the next few seconds
    // carry through the minute and often the hour, the day, the month and the
    // year. Years are biased towards leap and century boundaries.
    function automatic command_t rollover_command();
        command_t c;
        c.kind = tdcc_pkg::KIND_SET;
        case ($urandom_range(0, 3))
            0: c.when.year = 16'($urandom());
            1: c.when.year = 16'(100 * $urandom_range(0, 655));
            2: c.when.year = 16'(4 * $urandom_range(0, 16383));
            default: c.when.year = 16'(65535 - $urandom_range(0, 1));
        endcase
        c.when.month  = ($urandom_range(0, 2) == 0) ? 4'd12 : 4'($urandom_range(1, 12));
        c.when.day    = 5'($urandom_range(27, 31));
        c.when.hour   = ($urandom_range(0, 3) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
        c.when.minute = ($urandom_range(0, 3) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
        c.when.second = 6'($urandom_range(57, 59));
        return c;
    endfunction

    // Offers one input transaction and returns once it has been accepted.
    // Valid is only lowered when a gap is due, so back-to-back transactions
    // never see valid fall and rise in the same time step.
    task automatic send_command(input command_t c, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= c.kind;
        s_set_year   <= c.when.year;
        s_set_month  <= c.when.month;
        s_set_day    <= c.when.day;
        s_set_hour   <= c.when.hour;
        s_set_minute <= c.when.minute;
        s_set_second <= c.when.second;
        do @(posedge aclk); while (!s_ready);
        clock_model.accept_command(c);
    endtask

    task automatic send_tick();
        send_command(random_command(tdcc_pkg::KIND_TICK), 0);
    endtask

    // Loads the given date and time, then ticks once. With one tick to the
    // second this exercises a single step of the carry chain.
    task automatic load_then_tick(input logic [15:0] year, input logic [3:0] month,
                                  input logic [4:0] day, input logic [4:0] hour,
                                  input logic [5:0] minute, input logic [5:0] second);
        command_t c;
        c.kind        = tdcc_pkg::KIND_SET;
        c.when.year   = year;
        c.when.month  = month;
        c.when.day    = day;
        c.when.hour   = hour;
        c.when.minute = minute;
        c.when.second = second;
        send_command(c, 0);
        send_tick();
    endtask

    // Stops offering and waits until every queued reading has been seen.
    // Every transaction yields a result, so the block is idle afterwards.
    task automatic drain_readings();
        s_valid <= 1'b0;
        while (clock_model.expected_readings.size() != 0) @(posedge aclk);
    endtask

    // Writes the prescaler length through the configuration port, then reads
    // it back. The register is written at the edge that closes the access
    // phase; prdata is sampled at the edge that closes the read access.
    task automatic write_tick_rate(input logic [15:0] rate);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tdcc_pkg::ADDR_TICKS_PER_SECOND;
        pwdata  <= {16'd0, rate};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        clock_model.ticks_per_second = rate;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== {16'd0, rate}) begin
            $error("ticks_per_second: expected %0d, got %0d", rate, prdata);
            clock_model.errors++;
        end
    endtask

    // A stretch of random transactions: mostly ticks, with loads that lead
    // into rollovers and a few loads of arbitrary bits.
    task automatic random_phase(input int count, input bit with_hold);
        command_t c;
        int       r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                c = rollover_command();
            else if (r < 11)
                c = random_command(tdcc_pkg::KIND_SET);
            else
                c = random_command(tdcc_pkg::KIND_TICK);
            if (with_hold && i == count / 2)
                hold_request = 1'b1;
            send_command(c, pick_gap(send_calm));
        end
    endtask

    // Receiver. Each result transaction is checked at the edge where it is
    // accepted, using the values that stood before that edge. The receiver
    // stalls at random, and once for a long stretch when asked to.
    initial begin
        int       calm;
        int       gap;
        reading_t got;
        calm = 0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.now.year   = m_year_now;
                got.now.month  = m_month_now;
                got.now.day    = m_day_now;
                got.now.hour   = m_hour_now;
                got.now.minute = m_minute_now;
                got.now.second = m_second_now;
                got.pulse      = m_second_pulse;
                got.ticks      = m_tick_total;
                clock_model.compare_reading(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap(calm);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and the final verdict.
    initial begin
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= 32'd0;
        s_valid      <= 1'b0;
        s_kind       <= tdcc_pkg::KIND_TICK;
        s_set_year   <= 16'd0;
        s_set_month  <= 4'd0;
        s_set_day    <= 5'd0;
        s_set_hour   <= 5'd0;
        s_set_minute <= 6'd0;
        s_set_second <= 6'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Straight after reset the clock reads midnight on the first of
        // January 2000, and with the reset prescaler no tick makes a second.
        send_tick();
        send_tick();
        drain_readings();

        // With one tick to the second every tick advances the calendar.
        write_tick_rate(16'd1);
        // New year, carrying through every field.
        load_then_tick(16'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        // A century that is not a leap year, and one that is.
        load_then_tick(16'd2100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        load_then_tick(16'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        // The year wraps to zero, and year zero has a 29th of February.
        load_then_tick(16'd65535, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        load_then_tick(16'd0, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        // All load fields at their widest: the second wraps within its
        // width to zero and carries nothing.
        load_then_tick(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
        // Month zero with day 31: the day overflows its width and month zero
        // becomes January.
        load_then_tick(16'd2023, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59);
        // A second above its range carries on its next increment, all the
        // way into the first of May.
        load_then_tick(16'd2023, 4'd4, 5'd30, 5'd23, 6'd59, 6'd60);
        // A day beyond the month length carries into the month when it is
        // incremented.
        load_then_tick(16'd2023, 4'd2, 5'd30, 5'd23, 6'd59, 6'd59);
        // Month fifteen wraps to January of the next year.
        load_then_tick(16'd2023, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59);
        drain_readings();

        // A prescaler length of zero makes a second on every tick.
        write_tick_rate(16'd0);
        send_tick();
        send_tick();
        drain_readings();

        // Longest prescaler, then shortened below the count already reached:
        // the very next tick completes a second.
        write_tick_rate(16'hFFFF);
        send_tick();
        send_tick();
        send_tick();
        drain_readings();
        write_tick_rate(16'd2);
        send_tick();
        drain_readings();

        // Random phases under several prescaler lengths. In the first one
        // the receiver holds off for a long stretch while transactions keep
        // coming, so the block fills and stalls its input. Between phases
        // the sender waits until every reading has come back.
        write_tick_rate(16'd1);
        random_phase(RANDOM_ITEMS, 1'b1);
        drain_readings();
        write_tick_rate(16'd3);
        random_phase(RANDOM_ITEMS, 1'b0);
        drain_readings();
        write_tick_rate(16'd0);
        random_phase(RANDOM_ITEMS, 1'b0);
        drain_readings();
        write_tick_rate(16'd2);
        random_phase(RANDOM_ITEMS, 1'b0);
        drain_readings();
        write_tick_rate(16'($urandom_range(4, 9)));
        random_phase(RANDOM_ITEMS, 1'b0);
        drain_readings();

        // Give any stray result transaction time to show up.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (clock_model.errors == 0 && clock_model.expected_readings.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
